[src/u8d_pkg.sv]
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned LeftW = 3;

  localparam logic [UnitW-1:0] ReplacementUnit = 16'hFFFD;
  localparam logic [ByteW-1:0] Lead2Mask       = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask       = 8'h0F;

  // Continuation bytes still expected after each lead kind
  localparam logic [LeftW-1:0] Follow2 = 3'd1;
  localparam logic [LeftW-1:0] Follow3 = 3'd2;
  localparam logic [LeftW-1:0] Follow4 = 3'd3;
  localparam logic [LeftW-1:0] Follow5 = 3'd4;
  localparam logic [LeftW-1:0] Follow6 = 3'd5;
  localparam logic [LeftW-1:0] NoneLeft = 3'd0;
  localparam logic [LeftW-1:0] LastLeft = 3'd1;

  // Input register contents handed to the decoder
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_stage_t;

  // Decoder result handed to the output register
  typedef struct packed {
    logic             valid;
    logic [UnitW-1:0] code_unit;
    logic             replaced;
  } unit_stage_t;

endpackage

[src/u8d_if.sv]
interface u8d_byte_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface u8d_unit_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::UnitW-1:0] code_unit;
  logic                      replaced;

  modport source (output valid, output code_unit, output replaced, input ready);
  modport sink (input valid, input code_unit, input replaced, output ready);
endinterface

[src/utf8_to_ucs2_decoder_top.sv]
// UTF-8 to 16-bit code unit decoder. Feed one byte of a UTF-8 stream per
// word on byte_stream; a word appears on unit_stream each time a sequence
// completes. One- to three-byte sequences give their code point (truncated
// to 16 bits); four- to six-byte sequences are swallowed whole and give
// 0xFFFD with replaced set. Stray continuation bytes and 0xFE/0xFF leads pass
// through as their raw value. Continuation bytes are never checked, and an
// unfinished sequence simply waits for more bytes. The block takes one byte
// every clock unless stalled: a byte is held in the input register and
// decoded, and its unit (if any) is then registered in the output register
// and shown from there. It stalls only while a finished unit waits in the
// output register and the sink holds ready low.
module utf8_to_ucs2_decoder_top (
  input logic         clk,
  input logic         rst,
  u8d_byte_if.sink    byte_stream,
  u8d_unit_if.source  unit_stream
);
  import u8d_pkg::*;

  byte_stage_t stage;
  unit_stage_t result;
  logic        advance;
  logic        out_free;

  // Input register: hold the accepted byte for the decoder
  u8d_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_stream.valid),
    .in_data  (byte_stream.byte_in),
    .in_ready (byte_stream.ready),
    .advance  (advance),
    .stage    (stage)
  );

  // Decoder: classify leads, gather continuation bits, advance the sequence
  u8d_core u_core (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .advance  (advance),
    .result   (result)
  );

  // Output register: drop the unit onto the sink side
  u8d_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .result        (result),
    .advance       (advance),
    .out_free      (out_free),
    .out_valid     (unit_stream.valid),
    .out_code_unit (unit_stream.code_unit),
    .out_replaced  (unit_stream.replaced),
    .out_ready     (unit_stream.ready)
  );
endmodule

[src/u8d_in_reg.sv]
module u8d_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [u8d_pkg::ByteW-1:0] in_data,
  output logic                      in_ready,
  input  logic                      advance,
  output u8d_pkg::byte_stage_t      stage
);
  import u8d_pkg::*;

  logic             valid;
  logic [ByteW-1:0] data;

  // Take a new word when empty or when the held one moves on
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

  assign stage.valid = valid;
  assign stage.data  = data;
endmodule

[src/u8d_core.sv]
module u8d_core (
  input  logic                 clk,
  input  logic                 rst,
  input  u8d_pkg::byte_stage_t stage,
  input  logic                 out_free,
  output logic                 advance,
  output u8d_pkg::unit_stage_t result
);
  import u8d_pkg::*;

  logic [UnitW-1:0] accumulator, accumulator_next;
  logic [LeftW-1:0] bytes_left, bytes_left_next;
  logic             long_sequence, long_sequence_next;
  logic [UnitW-1:0] shifted;

  assign shifted = long_sequence ? accumulator
                                 : {accumulator[UnitW-7:0], stage.data[5:0]};

  always_comb begin
    accumulator_next   = accumulator;
    bytes_left_next    = bytes_left;
    long_sequence_next = long_sequence;
    result.valid       = 1'b0;
    result.code_unit   = {{(UnitW-ByteW){1'b0}}, stage.data};
    result.replaced    = 1'b0;
    if (bytes_left == NoneLeft) begin
      unique casez (stage.data)
        8'b110?????: begin
          bytes_left_next    = Follow2;
          accumulator_next   = {{(UnitW-ByteW){1'b0}}, stage.data & Lead2Mask};
          long_sequence_next = 1'b0;
        end
        8'b1110????: begin
          bytes_left_next    = Follow3;
          accumulator_next   = {{(UnitW-ByteW){1'b0}}, stage.data & Lead3Mask};
          long_sequence_next = 1'b0;
        end
        8'b11110???: begin
          bytes_left_next    = Follow4;
          accumulator_next   = '0;
          long_sequence_next = 1'b1;
        end
        8'b111110??: begin
          bytes_left_next    = Follow5;
          accumulator_next   = '0;
          long_sequence_next = 1'b1;
        end
        8'b1111110?: begin
          bytes_left_next    = Follow6;
          accumulator_next   = '0;
          long_sequence_next = 1'b1;
        end
        default: begin
          // ASCII, stray continuation bytes and 0xFE/0xFF leads pass through as raw bytes
          result.valid = 1'b1;
        end
      endcase
    end else begin
      bytes_left_next  = bytes_left - LastLeft;
      accumulator_next = shifted;
      if (bytes_left == LastLeft) begin
        result.valid       = 1'b1;
        result.code_unit   = long_sequence ? ReplacementUnit : shifted;
        result.replaced    = long_sequence;
        accumulator_next   = '0;
        long_sequence_next = 1'b0;
      end
    end
  end

  // Hold the byte only while a finished unit has nowhere to go
  assign advance = stage.valid && (!result.valid || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      bytes_left    <= NoneLeft;
      long_sequence <= 1'b0;
    end else if (advance) begin
      accumulator   <= accumulator_next;
      bytes_left    <= bytes_left_next;
      long_sequence <= long_sequence_next;
    end
  end
endmodule

[src/u8d_out_reg.sv]
module u8d_out_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  u8d_pkg::unit_stage_t      result,
  input  logic                      advance,
  output logic                      out_free,
  output logic                      out_valid,
  output logic [u8d_pkg::UnitW-1:0] out_code_unit,
  output logic                      out_replaced,
  input  logic                      out_ready
);
  import u8d_pkg::*;

  logic             valid;
  logic [UnitW-1:0] code_unit;
  logic             replaced;
  logic             load;

  assign out_free = !valid || out_ready;
  assign load     = advance && result.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit <= result.code_unit;
      replaced  <= result.replaced;
    end
  end

  assign out_valid     = valid;
  assign out_code_unit = code_unit;
  assign out_replaced  = replaced;
endmodule

[verif/utf8_to_ucs2_decoder_checker.sv]
module utf8_to_ucs2_decoder_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       end_of_test,
  u8d_byte_if        byte_stream,
  u8d_unit_if        unit_stream,
  output int         errors,
  output int         pending_units,
  output int         units_checked,
  output int         replacements_seen
);
  import u8d_pkg::*;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             replaced;
  } unit_word_t;

  unit_word_t expected_units[$];

  // Shadow decoder state
  logic [UnitW-1:0] shadow_acc;
  logic [LeftW-1:0] shadow_left;
  logic             shadow_long;
  bit               leftovers_done;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Advance the shadow decoder by one byte; return 1 when a unit completes
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output unit_word_t u);
    u = '0;
    if (shadow_left == NoneLeft) begin
      casez (b)
        8'b110?????: begin
          shadow_left = Follow2;
          shadow_acc  = UnitW'(b & Lead2Mask);
          shadow_long = 1'b0;
          return 1'b0;
        end
        8'b1110????: begin
          shadow_left = Follow3;
          shadow_acc  = UnitW'(b & Lead3Mask);
          shadow_long = 1'b0;
          return 1'b0;
        end
        8'b11110???: begin
          shadow_left = Follow4;
          shadow_acc  = '0;
          shadow_long = 1'b1;
          return 1'b0;
        end
        8'b111110??: begin
          shadow_left = Follow5;
          shadow_acc  = '0;
          shadow_long = 1'b1;
          return 1'b0;
        end
        8'b1111110?: begin
          shadow_left = Follow6;
          shadow_acc  = '0;
          shadow_long = 1'b1;
          return 1'b0;
        end
        default: begin
          // ASCII, stray continuation and 0xFE/0xFF all pass raw
          u.code_unit = UnitW'(b);
          u.replaced  = 1'b0;
          return 1'b1;
        end
      endcase
    end
    if (!shadow_long) shadow_acc = {shadow_acc[UnitW-7:0], b[5:0]};
    shadow_left = shadow_left - LastLeft;
    if (shadow_left != NoneLeft) return 1'b0;
    if (shadow_long) begin
      u.code_unit = ReplacementUnit;
      u.replaced  = 1'b1;
    end else begin
      u.code_unit = shadow_acc;
      u.replaced  = 1'b0;
    end
    shadow_acc  = '0;
    shadow_long = 1'b0;
    return 1'b1;
  endfunction

  initial begin
    errors            = 0;
    units_checked     = 0;
    replacements_seen = 0;
    pending_units     = 0;
    leftovers_done    = 1'b0;
    shadow_acc        = '0;
    shadow_left       = NoneLeft;
    shadow_long       = 1'b0;
  end

  always @(posedge clk) begin
    unit_word_t predicted;
    unit_word_t oldest;
    if (rst) begin
      shadow_acc  = '0;
      shadow_left = NoneLeft;
      shadow_long = 1'b0;
      expected_units.delete();
    end else begin
      // Compare first: a unit never stems from a byte taken at the same edge
      if (unit_stream.valid && unit_stream.ready) begin
        units_checked++;
        if (unit_stream.replaced) replacements_seen++;
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("unexpected unit %h replaced=%0b",
                                    unit_stream.code_unit, unit_stream.replaced));
        end else begin
          oldest = expected_units.pop_front();
          if (unit_stream.code_unit !== oldest.code_unit)
            report_mismatch($sformatf("code_unit %h, expected %h",
                                      unit_stream.code_unit, oldest.code_unit));
          if (unit_stream.replaced !== oldest.replaced)
            report_mismatch($sformatf("replaced %b, expected %b (unit %h)",
                                      unit_stream.replaced, oldest.replaced,
                                      oldest.code_unit));
        end
      end
      if (byte_stream.valid && byte_stream.ready) begin
        if (decode_byte(byte_stream.byte_in, predicted)) expected_units.push_back(predicted);
      end
      if (end_of_test && !leftovers_done) begin
        leftovers_done = 1'b1;
        foreach (expected_units[i])
          report_mismatch($sformatf("unit %h replaced=%0b never arrived",
                                    expected_units[i].code_unit,
                                    expected_units[i].replaced));
      end
    end
    pending_units = expected_units.size();
  end

endmodule

[verif/utf8_to_ucs2_decoder_top_tb.sv]
module utf8_to_ucs2_decoder_top_tb;
  import u8d_pkg::*;

  logic clk;
  logic rst;
  logic end_of_test;

  // Idle control: a steady flag turns off the random gaps on that side
  bit steady_in;
  bit steady_out;

  int bytes_sent;
  int check_errors;
  int pending_units;
  int units_checked;
  int replacements_seen;

  u8d_byte_if byte_stream ();
  u8d_unit_if unit_stream ();

  utf8_to_ucs2_decoder_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .unit_stream (unit_stream)
  );

  utf8_to_ucs2_decoder_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .end_of_test       (end_of_test),
    .byte_stream       (byte_stream),
    .unit_stream       (unit_stream),
    .errors            (check_errors),
    .pending_units     (pending_units),
    .units_checked     (units_checked),
    .replacements_seen (replacements_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung handshake
  initial begin
    #400000;
    $display("** utf8_to_ucs2_decoder_top: FAILED **");
    $finish;
  end

  // Push one byte as a word: idle a random number of cycles, then hold valid
  // until the block takes it. Drive only at the falling edge.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      byte_stream.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_stream.valid   <= 1'b1;
    byte_stream.byte_in <= b;
    @(posedge clk);
    while (!byte_stream.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Continuation byte: mostly well formed, sometimes anything at all since
  // the block never checks the top two bits
  function automatic logic [ByteW-1:0] follow_byte();
    if ($urandom_range(0, 99) < 85) return {2'b10, 6'($urandom_range(0, 63))};
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic send_follows(input int count);
    repeat (count) send_byte(follow_byte());
  endtask

  // Send one random sequence: ASCII, a 2..6-byte sequence, a stray byte or bad lead, or noise
  task automatic send_random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(ByteW'($urandom_range(0, 127)));
    end else if (pick < 52) begin
      send_byte({3'b110, 5'($urandom_range(0, 31))});
      send_follows(1);
    end else if (pick < 69) begin
      send_byte({4'b1110, 4'($urandom_range(0, 15))});
      send_follows(2);
    end else if (pick < 74) begin
      send_byte({5'b11110, 3'($urandom_range(0, 7))});
      send_follows(3);
    end else if (pick < 78) begin
      send_byte({6'b111110, 2'($urandom_range(0, 3))});
      send_follows(4);
    end else if (pick < 82) begin
      send_byte({7'b1111110, 1'($urandom_range(0, 1))});
      send_follows(5);
    end else if (pick < 90) begin
      // Stray continuation or 0xFE/0xFF lead
      if ($urandom_range(0, 3) == 0) send_byte({7'b1111111, 1'($urandom_range(0, 1))});
      else send_byte({2'b10, 6'($urandom_range(0, 63))});
    end else begin
      // Noise: may cut a sequence short or start one that the next picks finish
      send_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  // Sink: stall a random number of cycles before each word, then hold ready
  // until a word is taken
  initial begin
    int stall;
    unit_stream.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        unit_stream.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      unit_stream.ready <= 1'b1;
      @(posedge clk);
      while (!unit_stream.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int guard;
    rst                 = 1'b1;
    end_of_test         = 1'b0;
    byte_stream.valid   = 1'b0;
    byte_stream.byte_in = '0;
    bytes_sent          = 0;
    steady_in           = 1'b0;
    steady_out          = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single-byte extremes, bad leads, then each sequence length
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hBF);
    send_byte(8'hFE);
    send_byte(8'hFF);
    // Two bytes, continuation 0x00 taken as is
    send_byte(8'hDF);
    send_byte(8'h00);
    send_byte(8'hE2);
    send_byte(8'h82);
    send_byte(8'hAC);
    // Three bytes filling all 16 bits, continuation top bits ignored
    send_byte(8'hEF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // Four, five and six bytes: all give the replacement unit
    send_byte(8'hF0);
    send_follows(3);
    send_byte(8'hF8);
    send_follows(4);
    send_byte(8'hFC);
    send_follows(5);

    // Random: switch idling per phase so both busy and gappy stretches occur
    while (bytes_sent < 550) begin
      if ((bytes_sent % 60) < 8) begin
        steady_in  = ($urandom_range(0, 2) == 0);
        steady_out = ($urandom_range(0, 2) == 0);
      end
      send_random_sequence();
    end
    byte_stream.valid <= 1'b0;

    // Drain: wait for every predicted unit, then let the pipeline settle
    guard = 0;
    while (pending_units != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Summary: %0d bytes decoded into %0d units, %0d of them replacements",
             bytes_sent, units_checked, replacements_seen);
    if (check_errors == 0) begin
      $display("** utf8_to_ucs2_decoder_top: PASSED **");
    end else begin
      $display("** utf8_to_ucs2_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
src/u8d_pkg.sv
src/u8d_if.sv
src/u8d_in_reg.sv
src/u8d_core.sv
src/u8d_out_reg.sv
src/utf8_to_ucs2_decoder_top.sv
verif/utf8_to_ucs2_decoder_checker.sv
verif/utf8_to_ucs2_decoder_top_tb.sv
